// File: sv/icf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the instruction cache fetch block.
// No dependencies; every other file of the block except icf_channels imports this package.
package icf_pkg;

  // A cache line holds four words, one per store bank.
  localparam int LINE_WORDS = 4;

  // Fetches at or above this byte address bypass the cache.
  localparam logic [31:0] UNCACHED_BASE = 32'hA000_0000;

  // Configuration port address width and register indexes (word index in paddr[2]).
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_CACHE_ENABLE = 1'b0;

  // Result kinds.
  localparam logic [1:0] KIND_HIT      = 2'd0;
  localparam logic [1:0] KIND_FILL     = 2'd1;
  localparam logic [1:0] KIND_UNCACHED = 2'd2;

  // One tag store entry: valid marker and word address bits 31..2.
  typedef struct packed {
    logic        valid;
    logic [29:0] tag;
  } icf_tag_t;

  // Per-bank write enables for the tag and data banks.
  typedef struct packed {
    logic [LINE_WORDS-1:0] tag;
    logic [LINE_WORDS-1:0] data;
  } icf_wen_t;

endpackage

// File: sv/icf_channels.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for fetch requests and fetch results.
// No dependencies.
interface icf_fetch_if;
  logic        valid;
  logic        ready;
  logic [31:0] fetch_address;
  logic [31:0] line_word0;
  logic [31:0] line_word1;
  logic [31:0] line_word2;
  logic [31:0] line_word3;

  modport source (output valid, fetch_address, line_word0, line_word1, line_word2,
                  line_word3, input ready);
  modport sink (input valid, fetch_address, line_word0, line_word1, line_word2,
                line_word3, output ready);
endinterface

interface icf_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;
  logic [1:0]  fetch_kind;

  modport source (output valid, instruction, fetch_kind, input ready);
  modport sink (input valid, instruction, fetch_kind, output ready);
endinterface

// File: sv/icf_cfg_regs.sv
`timescale 1ns / 1ps
// APB-style configuration register file holding the cache enable bit.
// Depends on icf_pkg for the address width and register indexes.
module icf_cfg_regs import icf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic                  cache_enable
);

  logic cache_enable_r;
  logic cache_enable_nxt;
  logic wr_fire;

  // The access phase of a write completes a transfer; no wait states.
  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite && pready;

  // Writes to addresses beyond the register list are dropped.
  always_comb begin
    cache_enable_nxt = cache_enable_r;
    if (wr_fire && (paddr[2] == REG_CACHE_ENABLE)) begin
      cache_enable_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_enable_r <= 1'b0;
    end else begin
      cache_enable_r <= cache_enable_nxt;
    end
  end

  // Read data; unmapped addresses read as zero.
  assign prdata = (paddr[2] == REG_CACHE_ENABLE) ? {31'd0, cache_enable_r} : 32'd0;

  assign cache_enable = cache_enable_r;

endmodule

// File: sv/icf_store.sv
`timescale 1ns / 1ps
// Banked tag and data stores: one bank per word of a line, one row per line.
// Depends on icf_pkg for the tag entry and write enable types.
module icf_store import icf_pkg::*; #(
  parameter int ROWS = 256
) (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [$clog2(ROWS)-1:0] rd_row,
  input  logic [$clog2(ROWS)-1:0] wr_row,
  input  icf_wen_t                wen,
  input  icf_tag_t                tag_wd  [LINE_WORDS],
  input  logic [31:0]             data_wd [LINE_WORDS],
  output icf_tag_t                tag_rd  [LINE_WORDS],
  output logic [31:0]             data_rd [LINE_WORDS]
);

  icf_tag_t    tag_mem  [LINE_WORDS][ROWS];
  logic [31:0] data_mem [LINE_WORDS][ROWS];

  // Tag banks: one write and one registered read per bank each cycle.
  always_ff @(posedge clk) begin
    for (int b = 0; b < LINE_WORDS; b++) begin
      if (wen.tag[b]) begin
        tag_mem[b][wr_row] <= tag_wd[b];
      end
      if (rd_en) begin
        tag_rd[b] <= tag_mem[b][rd_row];
      end
    end
  end

  // Data banks: contents are undefined until written.
  always_ff @(posedge clk) begin
    for (int b = 0; b < LINE_WORDS; b++) begin
      if (wen.data[b]) begin
        data_mem[b][wr_row] <= data_wd[b];
      end
      if (rd_en) begin
        data_rd[b] <= data_mem[b][rd_row];
      end
    end
  end

endmodule

// File: sv/instruction_cache_fetch_core.sv
`timescale 1ns / 1ps
// Direct-mapped instruction cache fetch core. Pipeline: the accepting edge reads the store and
// loads the lookup stage, whose result moves into the output register once that register is free.
// Throughput: one fetch per cycle while the output is not stalled; a fetch whose store read
// shares its edge with a fill of its row takes the new contents from a forwarding register
// beside the store banks. Reset: synchronous; the tag store is then cleared one row per cycle,
// first row to last, during which no fetch is accepted. Depends on icf_pkg, icf_channels,
// icf_cfg_regs and icf_store.
module instruction_cache_fetch_core import icf_pkg::*; #(
  parameter int CACHE_WORDS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  icf_fetch_if.sink             in_ch,
  icf_result_if.source          out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int IDX_W = $clog2(CACHE_WORDS);
  localparam int ROWS  = CACHE_WORDS / LINE_WORDS;
  localparam int ROW_W = IDX_W - 2;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [ROW_W-1:0]  clr_row_r, clr_row_nxt;

  logic              cache_enable;

  // Lookup stage registers.
  logic              s1_valid_r;
  logic              s1_fwd_r;
  logic [31:0]       s1_addr_r;
  logic [31:0]       s1_line_r [LINE_WORDS];

  // Forwarding copy of the last line fill.
  logic [ROW_W-1:0]      fwd_row_r;
  icf_tag_t              fwd_tag_r  [LINE_WORDS];
  logic [LINE_WORDS-1:0] fwd_dwe_r;
  logic [31:0]           fwd_data_r [LINE_WORDS];

  // Output register.
  logic              out_valid_r;
  logic [31:0]       out_instr_r;
  logic [1:0]        out_kind_r;

  // Store ports.
  logic [ROW_W-1:0]  rd_row;
  logic [ROW_W-1:0]  wr_row;
  icf_wen_t          wen;
  icf_tag_t          tag_wd  [LINE_WORDS];
  logic [31:0]       data_wd [LINE_WORDS];
  icf_tag_t          tag_rd  [LINE_WORDS];
  logic [31:0]       data_rd [LINE_WORDS];

  // Lookup stage combinational values.
  logic                  accept;
  logic                  s1_done;
  logic [29:0]           s1_word;
  logic [1:0]            s1_off;
  logic [ROW_W-1:0]      s1_row;
  logic                  use_fwd;
  icf_tag_t              ent_tag;
  logic [31:0]           ent_data;
  logic                  hit;
  logic                  uncached;
  logic                  fill_fire;
  logic [LINE_WORDS-1:0] fill_dmask;
  icf_tag_t              fill_tag [LINE_WORDS];
  logic [31:0]           line_sel;

  icf_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .cache_enable (cache_enable)
  );

  // Handshake: the lookup stage frees itself whenever the output register can take its result.
  assign s1_done     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = (state_r == ST_RUN) && (!s1_valid_r || s1_done);
  assign accept      = in_ch.valid && in_ch.ready;

  // Address decomposition of the fetch in the lookup stage.
  assign s1_word = s1_addr_r[31:2];
  assign s1_off  = s1_addr_r[3:2];
  assign s1_row  = s1_addr_r[IDX_W+1:4];
  assign rd_row  = in_ch.fetch_address[IDX_W+1:4];

  // A fetch read in the same cycle as a fill of its row sees the fill through the forwarding copy.
  assign use_fwd  = s1_fwd_r && (fwd_row_r == s1_row);
  assign ent_tag  = use_fwd ? fwd_tag_r[s1_off] : tag_rd[s1_off];
  assign ent_data = (use_fwd && fwd_dwe_r[s1_off]) ? fwd_data_r[s1_off] : data_rd[s1_off];

  assign hit       = ent_tag.valid && (ent_tag.tag == s1_word);
  assign uncached  = (s1_addr_r >= UNCACHED_BASE) || !cache_enable;
  assign fill_fire = s1_done && !hit && !uncached;
  assign line_sel  = s1_line_r[s1_off];

  // Fill contents: every word is retagged, words from the fetch offset on become valid.
  always_comb begin
    for (int w = 0; w < LINE_WORDS; w++) begin
      fill_dmask[w]     = (2'(w) >= s1_off);
      fill_tag[w].valid = fill_dmask[w];
      fill_tag[w].tag   = {s1_word[29:2], 2'(w)};
    end
  end

  // Store write port: the clearing pass owns it after reset, then line fills.
  always_comb begin
    for (int w = 0; w < LINE_WORDS; w++) begin
      data_wd[w] = s1_line_r[w];
      tag_wd[w]  = (state_r == ST_CLEAR) ? '0 : fill_tag[w];
    end
    if (state_r == ST_CLEAR) begin
      wr_row   = clr_row_r;
      wen.tag  = '1;
      wen.data = '0;
    end else begin
      wr_row   = s1_row;
      wen.tag  = fill_fire ? '1 : '0;
      wen.data = fill_fire ? fill_dmask : '0;
    end
  end

  icf_store #(
    .ROWS (ROWS)
  ) u_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_row  (rd_row),
    .wr_row  (wr_row),
    .wen     (wen),
    .tag_wd  (tag_wd),
    .data_wd (data_wd),
    .tag_rd  (tag_rd),
    .data_rd (data_rd)
  );

  // Clearing pass sequencer.
  always_comb begin
    state_nxt   = state_r;
    clr_row_nxt = clr_row_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_row_nxt = clr_row_r + 1'b1;
        if (clr_row_r == LAST_ROW) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_row_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_row_r <= clr_row_nxt;
    end
  end

  // Lookup stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_fwd_r   <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
        s1_fwd_r   <= fill_fire;
      end else if (s1_done) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Lookup stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r    <= in_ch.fetch_address;
      s1_line_r[0] <= in_ch.line_word0;
      s1_line_r[1] <= in_ch.line_word1;
      s1_line_r[2] <= in_ch.line_word2;
      s1_line_r[3] <= in_ch.line_word3;
    end
  end

  // Forwarding copy of each fill as it is written.
  always_ff @(posedge clk) begin
    if (fill_fire) begin
      fwd_row_r <= s1_row;
      fwd_dwe_r <= fill_dmask;
      for (int w = 0; w < LINE_WORDS; w++) begin
        fwd_tag_r[w]  <= fill_tag[w];
        fwd_data_r[w] <= s1_line_r[w];
      end
    end
  end

  // Output register; a fill returns the word just written, which is the line word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done) begin
      priority if (hit) begin
        out_instr_r <= ent_data;
        out_kind_r  <= KIND_HIT;
      end else if (uncached) begin
        out_instr_r <= line_sel;
        out_kind_r  <= KIND_UNCACHED;
      end else begin
        out_instr_r <= line_sel;
        out_kind_r  <= KIND_FILL;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.instruction = out_instr_r;
  assign out_ch.fetch_kind  = out_kind_r;

endmodule

// File: sv/icf_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the instruction cache fetch core, with its bind.
// Depends on icf_pkg for the result kind codes.
module icf_checker import icf_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_instruction,
  input logic [1:0]  out_fetch_kind
);

  // The clearing pass holds off fetches right after reset.
  a_ready_low_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("fetch accepted during the tag clearing pass");

  // Only the three defined result kinds are produced.
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fetch_kind == KIND_HIT || out_fetch_kind == KIND_FILL ||
                   out_fetch_kind == KIND_UNCACHED))
    else $error("undefined fetch kind on result");

  // A stalled result is neither withdrawn nor altered.
  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_instruction) && $stable(out_fetch_kind))
    else $error("result changed before transfer");

endmodule

bind instruction_cache_fetch_core icf_checker u_icf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_instruction (out_ch.instruction),
  .out_fetch_kind  (out_ch.fetch_kind)
);
